// File: rtl/wws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wws_pkg
// Shared types and constants of the windowed standard deviation block.
// ----------------------------------------------------------------------------
package wws_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int CNT_W          = 32;
	localparam int M2_W           = 64;
	localparam int TIME_W         = 32;
	localparam int OUT_W          = 32;
	localparam int CFG_W          = 32;
	localparam int CFG_IDX_W      = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 1'b1;

	typedef struct packed {
		logic load;
		logic div_mean;
		logic mean_upd;
		logic m2_add;
		logic div_var;
		logic sqrt_start;
		logic out_load;
		logic clear;
	} wws_cmd_t;

	typedef struct packed {
		logic kept;
		logic last;
		logic few;
		logic div_done;
		logic mul_done;
		logic sqrt_done;
		logic out_free;
	} wws_stat_t;

endpackage
`default_nettype wire

// File: rtl/wws_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wws_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wws_div #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [NW-1:0]      quotient
);

	localparam int CW = $clog2(NW);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// File: rtl/wws_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wws_dp
// Datapath: window test, Welford state, serial multiplier, square root, output.
// ----------------------------------------------------------------------------
module wws_dp
	import wws_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic [TIME_W-1:0]     sample_time,
	input  wire logic [VALUE_BITS-1:0] sample_value,
	input  wire logic                  last_sample,
	input  wire wws_cmd_t              cmd,
	output wws_stat_t                  stat,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [OUT_W-1:0]           std_dev,
	output logic [CNT_W-1:0]           used_count,
	output logic                       status
);

	localparam int MAGW = VALUE_BITS + 16;
	localparam int PW   = 2 * MAGW;
	localparam int MCW  = $clog2(MAGW);
	localparam int EXTW = 128;

	logic [TIME_W-1:0]      win_start_q, win_end_q;
	logic                   kept_q, last_q, neg_q;
	logic signed [MAGW-1:0] x_q, mean_q;
	logic [MAGW-1:0]        mag_q;
	logic [CNT_W-1:0]       count_q, count_inc;
	logic [M2_W-1:0]        m2_q;

	logic                   neg_c;
	logic [MAGW-1:0]        mag_c, q_c;

	logic                   div_start, div_busy, div_done;
	logic [M2_W-1:0]        div_num, div_quo;
	logic [CNT_W-1:0]       div_den;

	logic [MAGW-1:0]        ma_q;
	logic [PW-1:0]          mprod_q;
	logic [MCW-1:0]         mcnt_q;
	logic                   mbusy_q, mdone_q;
	logic [MAGW:0]          msum;
	logic [EXTW-1:0]        prod_ext;
	logic [M2_W-1:0]        inc;
	logic [M2_W:0]          m2_sum;

	logic [M2_W-1:0]        sv_q, sres_q, sbit_q, strial;
	logic                   sbusy_q, sdone_q;

	logic                   out_valid_q, status_q;
	logic [OUT_W-1:0]       std_q;
	logic [CNT_W-1:0]       used_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			win_end_q   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_START: win_start_q <= cfg_data;
				REG_WINDOW_END:   win_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign neg_c     = x_q < mean_q;
	assign mag_c     = neg_c ? MAGW'(mean_q - x_q) : MAGW'(x_q - mean_q);
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign q_c       = div_quo[MAGW-1:0];

	assign div_start = cmd.div_mean | cmd.div_var;
	assign div_num   = cmd.div_mean ? M2_W'(mag_c) : m2_q;
	assign div_den   = cmd.div_mean ? count_inc : count_q - 1'b1;

	wws_div #(.NW(M2_W), .DW(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sample capture and Welford state.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= {sample_value, 16'h0000};
			last_q <= last_sample;
			kept_q <= (sample_time >= win_start_q) && (sample_time <= win_end_q);
		end
		if (cmd.div_mean) begin
			mag_q <= mag_c;
			neg_q <= neg_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
		end else begin
			if (cmd.div_mean) count_q <= count_inc;
			if (cmd.mean_upd) mean_q <= neg_q ? mean_q - q_c : mean_q + q_c;
			if (cmd.m2_add)   m2_q <= m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
		end
	end

	// Shift-add multiplier for |delta| * |delta2|, one bit per cycle.
	assign msum = {1'b0, mprod_q[PW-1:MAGW]} + (mprod_q[0] ? {1'b0, ma_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.mean_upd) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= MCW'(MAGW - 1);
			end else if (mbusy_q) begin
				if (mcnt_q == '0) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
				mcnt_q <= mcnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mean_upd) begin
			ma_q    <= mag_q;
			mprod_q <= {{MAGW{1'b0}}, MAGW'(mag_q - q_c)};
		end else if (mbusy_q) begin
			mprod_q <= {msum, mprod_q[MAGW-1:1]};
		end
	end

	assign prod_ext = EXTW'(mprod_q);
	assign inc      = (prod_ext[EXTW-1:96] != '0) ? '1 : prod_ext[95:32];
	assign m2_sum   = {1'b0, m2_q} + {1'b0, inc};

	// Digit-by-digit integer square root, two radicand bits per cycle.
	assign strial = sres_q + sbit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
			sdone_q <= 1'b0;
		end else begin
			sdone_q <= 1'b0;
			if (cmd.sqrt_start) begin
				sbusy_q <= 1'b1;
			end else if (sbusy_q && sbit_q[0]) begin
				sbusy_q <= 1'b0;
				sdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sv_q   <= div_quo;
			sres_q <= '0;
			sbit_q <= M2_W'(1) << (M2_W - 2);
		end else if (sbusy_q) begin
			if (sv_q >= strial) begin
				sv_q   <= sv_q - strial;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			std_q    <= stat.few ? '0 : sres_q[OUT_W-1:0];
			used_q   <= count_q;
			status_q <= stat.few;
		end
	end

	assign stat.kept      = kept_q;
	assign stat.last      = last_q;
	assign stat.few       = count_q < CNT_W'(2);
	assign stat.div_done  = div_done;
	assign stat.mul_done  = mdone_q;
	assign stat.sqrt_done = sdone_q;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign std_dev    = std_q;
	assign used_count = used_q;
	assign status     = status_q;

`ifndef NO_ASSERTIONS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({div_busy, mbusy_q, sbusy_q}))
		else $error("more than one iterative unit active");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count_q == '0 && m2_q == '0))
		else $error("statistics not cleared after result");
`endif

endmodule
`default_nettype wire

// File: rtl/wws_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wws_ctrl
// Sequencer that steps one sample through the datapath.
// ----------------------------------------------------------------------------
module wws_ctrl
	import wws_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire wws_stat_t stat,
	output wws_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIVM  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_DIVV  = 3'd5;
	localparam logic [2:0] ST_SQRT  = 3'd6;
	localparam logic [2:0] ST_RES   = 3'd7;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.kept) begin
					cmd.div_mean = 1'b1;
					state_d      = ST_DIVM;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIVM: begin
				if (stat.div_done) begin
					cmd.mean_upd = 1'b1;
					state_d      = ST_MUL;
				end
			end
			ST_MUL: begin
				if (stat.mul_done) begin
					cmd.m2_add = 1'b1;
					state_d    = ST_FIN;
				end
			end
			ST_FIN: begin
				priority if (!stat.last) begin
					state_d = ST_IDLE;
				end else if (stat.few) begin
					state_d = ST_RES;
				end else begin
					cmd.div_var = 1'b1;
					state_d     = ST_DIVV;
				end
			end
			ST_DIVV: begin
				if (stat.div_done) begin
					cmd.sqrt_start = 1'b1;
					state_d        = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (stat.sqrt_done) state_d = ST_RES;
			end
			ST_RES: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/windowed_welford_std_dev.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_welford_std_dev
// Sample standard deviation of the samples inside a time window.
// ----------------------------------------------------------------------------
// Samples are taken one at a time. A sample outside the window only passes
// the window test; a sample inside it also goes through the radix-2 divider
// that forms delta/n and the bit-serial multiplier of VALUE_BITS+16 steps.
// The sample marked last then runs the variance division and the 32-step
// square root when two or more samples were kept.
// The result waits in an output register,
// so a new sample is taken while the previous result still waits for transfer.
module windowed_welford_std_dev
	import wws_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [TIME_W-1:0]     sample_time,
	input  wire logic [VALUE_BITS-1:0] sample_value,
	input  wire logic                  last_sample,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_W-1:0]           std_dev,
	output logic [CNT_W-1:0]           used_count,
	output logic                       status
);

	wws_cmd_t  cmd;
	wws_stat_t stat;

	wws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wws_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_time  (sample_time),
		.sample_value (sample_value),
		.last_sample  (last_sample),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.std_dev      (std_dev),
		.used_count   (used_count),
		.status       (status)
	);

endmodule
`default_nettype wire

// File: verif/wws_checker.sv
// ----------------------------------------------------------------------------
// wws_checker
// Watches the sample and result channels and the register port of the
// windowed standard deviation block. It keeps its own window registers and
// running statistics and compares each result transfer with the oldest
// predicted result.
// ----------------------------------------------------------------------------
module wws_checker
	import wws_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic [TIME_W-1:0]    sample_time,
	input  wire logic [31:0]          sample_value,
	input  wire logic                 last_sample,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [OUT_W-1:0]     std_dev,
	input  wire logic [CNT_W-1:0]     used_count,
	input  wire logic                 status,
	output int                        fail_count,
	output int                        pending,
	output int                        result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [OUT_W-1:0] std_dev;
		logic [CNT_W-1:0] used_count;
		logic             status;
	} wws_result_t;

	wws_result_t         result_q[$];
	logic [TIME_W-1:0]   win_lo;
	logic [TIME_W-1:0]   win_hi;
	logic [CNT_W-1:0]    kept;
	logic signed [63:0]  mean;
	logic [M2_W-1:0]     m2;

	assign pending = result_q.size();

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'h1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Welford update with the block's fixed-point rounding: the mean step is
	// truncated toward zero and the M2 increment is floored and saturated.
	task automatic absorb(logic [31:0] v);
		logic signed [63:0] x;
		logic [63:0]        mag;
		logic [63:0]        q;
		logic [63:0]        mag2;
		logic [127:0]       prod;
		logic [63:0]        inc;
		logic [64:0]        sum;
		logic               neg;
		x = {{32{v[31]}}, v} <<< 16;
		if (kept != '1)
			kept = kept + 1;
		neg = x < mean;
		mag = neg ? mean - x : x - mean;
		q = mag / {32'b0, kept};
		mean = neg ? mean - q : mean + q;
		mag2 = mag - q;
		prod = {64'b0, mag} * {64'b0, mag2};
		inc = (prod[127:96] != 0) ? '1 : prod[95:32];
		sum = {1'b0, m2} + {1'b0, inc};
		m2 = sum[64] ? '1 : sum[63:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		wws_result_t r;
		wws_result_t got;
		if (!arst_n) begin
			win_lo = '0;
			win_hi = '1;
			kept = '0;
			mean = '0;
			m2 = '0;
			result_q.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WINDOW_START)
					win_lo = cfg_data;
				else if (cfg_index == REG_WINDOW_END)
					win_hi = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (sample_time >= win_lo && sample_time <= win_hi)
					absorb(sample_value);
				if (last_sample) begin
					r.used_count = kept;
					if (kept < 2) begin
						r.std_dev = '0;
						r.status = 1'b1;
					end else begin
						r.std_dev = OUT_W'(root_floor(m2 / ({32'b0, kept} - 64'd1)));
						r.status = 1'b0;
					end
					result_q.push_back(r);
					kept = '0;
					mean = '0;
					m2 = '0;
				end
			end
			if (out_valid && out_ready) begin
				got = '{std_dev, used_count, status};
				result_count++;
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer: std_dev=%h count=%0d status=%b",
							std_dev, used_count, status);
				end else begin
					r = result_q.pop_front();
					if (r != got) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"result %0d: expected std_dev=%h count=%0d status=%b,",
								" got std_dev=%h count=%0d status=%b"},
								result_count, r.std_dev, r.used_count, r.status,
								got.std_dev, got.used_count, got.status);
					end
				end
			end
		end
	end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the windowed standard deviation block: directed waveforms for
// the extremes and the empty, short and saturating cases, then random
// waveforms under several window settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module testbench
	import wws_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [TIME_W-1:0]    sample_time;
	logic [31:0]          sample_value;
	logic                 last_sample;
	logic                 out_valid;
	logic                 out_ready;
	logic [OUT_W-1:0]     std_dev;
	logic [CNT_W-1:0]     used_count;
	logic                 status;
	int                   fail_count;
	int                   pending;
	int                   result_count;
	int                   send_idle_pct;
	int                   recv_idle_pct;
	int                   hold_left;
	int                   quiet_cycles;
	int                   sample_count;

	windowed_welford_std_dev dut (.*);

	wws_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random idling, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(logic [31:0] t, logic [31:0] v, logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		sample_time <= t;
		sample_value <= v;
		last_sample <= last;
		do
			@(posedge clk);
		while (!in_ready);
		sample_count++;
	endtask

	// Waits until every result has been transferred and the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_window(logic [31:0] lo, logic [31:0] hi);
		drain();
		write_reg(REG_WINDOW_START, lo);
		write_reg(REG_WINDOW_END, hi);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(400000)) - 200000);
		endcase
	endfunction

	// One waveform: mostly ordered times around the window, a few wild ones.
	task automatic random_wave(logic [31:0] lo, logic [31:0] hi);
		int          len;
		logic [31:0] t;
		len = $urandom_range(4) == 0 ? $urandom_range(40, 15) : $urandom_range(12, 1);
		t = (lo > 50) ? lo - $urandom_range(50) : lo;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				t = $urandom();
			else
				t = t + $urandom_range((hi - lo) / 8 + 2);
			send(t, pick_value(), i == len - 1);
		end
	endtask

	task automatic random_phase(int items, bit with_hold);
		logic [31:0] lo;
		logic [31:0] hi;
		int          start;
		start = sample_count;
		while (sample_count - start < items) begin
			case ($urandom_range(5))
				0: begin lo = '0; hi = '1; end
				1: begin lo = $urandom(); hi = $urandom(); end
				2: begin lo = 32'hFFFF_F000; hi = '1; end
				default: begin lo = $urandom_range(1000); hi = lo + $urandom_range(2000); end
			endcase
			set_window(lo, hi);
			if (with_hold && sample_count - start > items / 2) begin
				with_hold = 0;
				hold_left <= 3000;
			end
			repeat ($urandom_range(4, 2))
				random_wave(lo, hi);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WINDOW_START;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_time = '0;
		sample_value = '0;
		last_sample = 1'b0;
		out_ready = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		sample_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Too few samples, then extremes that drive M2 into saturation.
		send(32'd0, 32'h0001_0000, 1'b1);
		send(32'd1, 32'h7FFF_FFFF, 1'b0);
		send(32'd2, 32'h8000_0000, 1'b0);
		send(32'd3, 32'd0, 1'b1);
		for (int i = 0; i < 6; i++)
			send(32'hFFFF_FFFF, i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 5);
		// Window edges, samples outside it and a last sample outside it.
		set_window(32'd100, 32'd200);
		send(32'd50, 32'h1234_5678, 1'b0);
		send(32'd100, 32'h0002_0000, 1'b0);
		send(32'd150, 32'hFFFE_0000, 1'b0);
		send(32'd200, 32'h0000_8000, 1'b0);
		send(32'd99, 32'h0000_0001, 1'b0);
		send(32'd250, 32'h0005_0000, 1'b1);
		// Empty window.
		set_window(32'd300, 32'd100);
		send(32'd200, 32'h0001_0000, 1'b0);
		send(32'd300, 32'h0003_0000, 1'b1);
		// Windows pinned at both ends of the time range, times out of order.
		set_window(32'd0, 32'd0);
		send(32'd0, 32'h7FFF_FFFF, 1'b0);
		send(32'hFFFF_FFFF, 32'h1, 1'b0);
		send(32'd0, 32'hFFFF_FFFF, 1'b1);
		set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(32'hFFFF_FFFF, 32'h5555_5555, 1'b0);
		send(32'd0, 32'h0, 1'b0);
		send(32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b1);

		send_idle_pct = 33;
		recv_idle_pct = 88;
		random_phase(115, 0);
		send_idle_pct = 88;
		recv_idle_pct = 33;
		random_phase(115, 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(120, 1);

		drain();
		$display("%0d samples sent, %0d results checked over directed and random windows",
			sample_count, result_count);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/wws_pkg.sv
rtl/wws_div.sv
rtl/wws_dp.sv
rtl/wws_ctrl.sv
rtl/windowed_welford_std_dev.sv
verif/wws_checker.sv
verif/testbench.sv
